FILE: sv/tsc_pkg.sv
// shared types and constants for the touch swipe classifier
package tsc_pkg;

	localparam int TYPE_W = 5;
	localparam int CODE_W = 10;
	localparam int VAL_W = 12;
	localparam int THR_W = 12;
	localparam int GEST_W = 3;

	localparam int RAW_BITS_DEF = 12;

	localparam logic [TYPE_W-1:0] EV_TYPE_KEY = TYPE_W'(1);
	localparam logic [TYPE_W-1:0] EV_TYPE_ABS = TYPE_W'(3);
	localparam logic [CODE_W-1:0] CODE_ABS_X = CODE_W'(0);
	localparam logic [CODE_W-1:0] CODE_ABS_Y = CODE_W'(1);
	localparam logic [CODE_W-1:0] CODE_TOUCH = CODE_W'(330);
	localparam logic [VAL_W-1:0] BTN_PRESSED = VAL_W'(1);
	localparam logic [VAL_W-1:0] BTN_RELEASED = VAL_W'(0);
	localparam logic [THR_W-1:0] THRESH_RESET = THR_W'(50);

	typedef enum logic [GEST_W-1:0] {
		G_RIGHT = 3'd0,
		G_LEFT = 3'd1,
		G_UP = 3'd2,
		G_DOWN = 3'd3,
		G_TAP = 3'd4
	} gesture_t;

	typedef enum logic [2:0] {
		EV_NONE,
		EV_ABS_X,
		EV_ABS_Y,
		EV_PRESS,
		EV_RELEASE
	} ev_kind_t;

endpackage

FILE: sv/tsc_scale.sv
// raw axis value to screen pixels: x = v*800/1024, y = v*480/600
module tsc_scale import tsc_pkg::*; #(
	parameter int RAW_BITS = RAW_BITS_DEF
) (
	input  logic [VAL_W-1:0]    raw,
	output logic [RAW_BITS-1:0] x_scaled,
	output logic [RAW_BITS-1:0] y_scaled
);

	localparam int MASK_BITS = (RAW_BITS >= VAL_W) ? VAL_W : RAW_BITS;
	localparam logic [VAL_W-1:0] RAW_MASK = VAL_W'((33'd1 << MASK_BITS) - 33'd1);
	localparam int PX_W = VAL_W + 5;
	localparam int NY_W = VAL_W + 2;
	localparam int PY_W = NY_W + 16;
	// 2^18 / 5 rounded up, exact floor for every 14 bit numerator
	localparam logic [PY_W-1:0] RECIP5 = PY_W'(52429);

	logic [VAL_W-1:0] val_m;
	logic [PX_W-1:0]  prod_x;
	logic [NY_W-1:0]  num_y;
	logic [PY_W-1:0]  prod_y;
	logic [VAL_W-1:0] x12;
	logic [VAL_W-1:0] y12;

	assign val_m = raw & RAW_MASK;

	// 800/1024 reduces to 25/32
	assign prod_x = PX_W'(val_m) * PX_W'(25);
	assign x12 = prod_x[PX_W-1:5];

	// 480/600 reduces to 4/5
	assign num_y = {val_m, 2'b00};
	assign prod_y = PY_W'(num_y) * RECIP5;
	assign y12 = prod_y[PY_W-1:18];

	assign x_scaled = RAW_BITS'(x12);
	assign y_scaled = RAW_BITS'(y12);

endmodule

FILE: sv/tsc_classify.sv
// gesture decision from start and current point against the threshold
module tsc_classify import tsc_pkg::*; #(
	parameter int RAW_BITS = RAW_BITS_DEF
) (
	input  logic [RAW_BITS-1:0] cur_x,
	input  logic [RAW_BITS-1:0] cur_y,
	input  logic [RAW_BITS-1:0] start_x,
	input  logic [RAW_BITS-1:0] start_y,
	input  logic [THR_W-1:0]    threshold,
	output gesture_t            gesture
);

	localparam int CMP_W = (RAW_BITS > THR_W) ? RAW_BITS : THR_W;

	logic [RAW_BITS-1:0] d_right;
	logic [RAW_BITS-1:0] d_left;
	logic [RAW_BITS-1:0] d_up;
	logic [RAW_BITS-1:0] d_down;
	logic [CMP_W-1:0]    thr_ext;
	logic                is_right;
	logic                is_left;
	logic                is_up;
	logic                is_down;

	assign d_right = cur_x - start_x;
	assign d_left = start_x - cur_x;
	assign d_up = start_y - cur_y;
	assign d_down = cur_y - start_y;
	assign thr_ext = CMP_W'(threshold);

	// strict movement required even with a zero threshold
	assign is_right = (cur_x > start_x) && (CMP_W'(d_right) >= thr_ext);
	assign is_left = (start_x > cur_x) && (CMP_W'(d_left) >= thr_ext);
	assign is_up = (start_y > cur_y) && (CMP_W'(d_up) >= thr_ext);
	assign is_down = (cur_y > start_y) && (CMP_W'(d_down) >= thr_ext);

	always_comb begin
		if (is_right) begin
			gesture = G_RIGHT;
		end else if (is_left) begin
			gesture = G_LEFT;
		end else if (is_up) begin
			gesture = G_UP;
		end else if (is_down) begin
			gesture = G_DOWN;
		end else begin
			gesture = G_TAP;
		end
	end

endmodule

FILE: sv/touch_swipe_classifier_top.sv
// touch swipe classifier: event decode, position tracking and gesture output
//
// Takes one touch event item per clock while in_stall is low. An item is
// registered at the input, then decoded and applied to the tracked position;
// a release loads its gesture for out_valid. Axis scaling is a constant
// multiply (divide by 5 done by reciprocal) and the gesture decision is four
// subtract-and-compare paths, all combinational. in_stall rises only when a
// release item sits in the input register while a previous gesture is still
// held by out_stall; every other item moves on at once. Other than the input
// data and gesture registers, all state resets directly. The user writes the
// threshold through cfg_we/cfg_wdata only while idle; not enforced by the block.
module touch_swipe_classifier_top import tsc_pkg::*; #(
	parameter int RAW_BITS = RAW_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [THR_W-1:0]  cfg_wdata,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [TYPE_W-1:0] event_type,
	input  logic [CODE_W-1:0] event_code,
	input  logic [VAL_W-1:0]  event_value,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [GEST_W-1:0] gesture
);

	logic                valid_s1;
	logic [TYPE_W-1:0]   type_s1;
	logic [CODE_W-1:0]   code_s1;
	logic [VAL_W-1:0]    value_s1;

	logic [THR_W-1:0]    thr_q;
	logic [RAW_BITS-1:0] cur_x_q;
	logic [RAW_BITS-1:0] cur_y_q;
	logic [RAW_BITS-1:0] start_x_q;
	logic [RAW_BITS-1:0] start_y_q;
	logic                out_valid_q;
	gesture_t            gesture_q;

	ev_kind_t            kind;
	logic                adv;
	logic [RAW_BITS-1:0] x_scaled;
	logic [RAW_BITS-1:0] y_scaled;
	gesture_t            gest_next;

	tsc_scale #(
		.RAW_BITS(RAW_BITS)
	) u_scale (
		.raw(value_s1),
		.x_scaled(x_scaled),
		.y_scaled(y_scaled)
	);

	tsc_classify #(
		.RAW_BITS(RAW_BITS)
	) u_classify (
		.cur_x(cur_x_q),
		.cur_y(cur_y_q),
		.start_x(start_x_q),
		.start_y(start_y_q),
		.threshold(thr_q),
		.gesture(gest_next)
	);

	always_comb begin
		kind = EV_NONE;
		if (type_s1 == EV_TYPE_ABS) begin
			if (code_s1 == CODE_ABS_X) begin
				kind = EV_ABS_X;
			end else if (code_s1 == CODE_ABS_Y) begin
				kind = EV_ABS_Y;
			end
		end else if (type_s1 == EV_TYPE_KEY && code_s1 == CODE_TOUCH) begin
			if (value_s1 == BTN_PRESSED) begin
				kind = EV_PRESS;
			end else if (value_s1 == BTN_RELEASED) begin
				kind = EV_RELEASE;
			end
		end
	end

	// only a release needs room in the result register
	assign adv = valid_s1 && !(kind == EV_RELEASE && out_valid_q && out_stall);
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			type_s1 <= event_type;
			code_s1 <= event_code;
			value_s1 <= event_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THRESH_RESET;
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q <= '0;
			cur_y_q <= '0;
			start_x_q <= '0;
			start_y_q <= '0;
		end else if (adv) begin
			case (kind)
				EV_ABS_X: begin
					cur_x_q <= x_scaled;
				end
				EV_ABS_Y: begin
					cur_y_q <= y_scaled;
				end
				EV_PRESS: begin
					start_x_q <= cur_x_q;
					start_y_q <= cur_y_q;
				end
				EV_RELEASE: begin
					start_x_q <= '0;
					start_y_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && kind == EV_RELEASE) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && kind == EV_RELEASE) begin
			gesture_q <= gest_next;
		end
	end

	assign out_valid = out_valid_q;
	assign gesture = gesture_q;

`ifndef NO_ASSERTIONS
	a_stall_only_release: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && kind == EV_RELEASE && out_valid_q && out_stall))
		else $error("input stalled without a blocked release");

	a_release_result: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && kind == EV_RELEASE) |=> (out_valid_q && gesture_q == $past(gest_next)))
		else $error("release did not load its gesture");

	a_start_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && kind == EV_RELEASE) |=> (start_x_q == '0 && start_y_q == '0))
		else $error("start point not cleared after release");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall && !(adv && kind == EV_RELEASE)) |=>
			(out_valid_q && $stable(gesture_q)))
		else $error("held gesture lost");
`endif

endmodule
